// ===== hw/rtl/catmull_rom_polyline_tessellator_defines.svh =====
// ----------------------------------------------------------------------------
// catmull-rom tessellator assertion macros
// shared property forms for the tessellator checks, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_POLYLINE_TESSELLATOR_DEFINES_SVH
`define CATMULL_ROM_POLYLINE_TESSELLATOR_DEFINES_SVH

// same-cycle implication
`define CRT_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tessellator check failed");

// next-cycle implication
`define CRT_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tessellator check failed");

`endif

// ===== hw/rtl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// shared constants, job codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MAX_STEPS_DEF = 31;
  localparam int CW  = 16;
  localparam int VW  = 9;
  localparam int SPW = 12;
  localparam int AW  = 3;

  localparam logic [AW-1:0]  ADDR_SPACING  = 3'd0;
  localparam logic [SPW-1:0] SPACING_RESET = 12'd64;
  localparam logic [SPW-1:0] MIN_SPACING   = 12'd32;

  localparam int JW = 3;
  localparam logic [JW-1:0] JOB_X1 = 3'd0;
  localparam logic [JW-1:0] JOB_X2 = 3'd1;
  localparam logic [JW-1:0] JOB_X3 = 3'd2;
  localparam logic [JW-1:0] JOB_Y1 = 3'd3;
  localparam logic [JW-1:0] JOB_Y2 = 3'd4;
  localparam logic [JW-1:0] JOB_Y3 = 3'd5;
  localparam logic [JW-1:0] JOB_V  = 3'd6;

  localparam logic SEG_MAIN = 1'b0;
  localparam logic SEG_TAIL = 1'b1;

  typedef struct packed {
    logic          latch;
    logic          load;
    logic          sq_dx;
    logic          sq_dy;
    logic          step;
    logic          n2;
    logic          n3;
    logic          prep1;
    logic          prep2;
    logic          div_start;
    logic          div_store;
    logic          run_init;
    logic          emit_sample;
    logic          emit_last;
    logic          finish;
    logic          seg;
    logic [JW-1:0] job;
  } crt_cmd_t;

  typedef struct packed {
    logic [1:0] points_seen;
    logic       series_end;
    logic       step_go;
    logic       div_done;
    logic       out_free;
    logic       k_last;
  } crt_stat_t;

endpackage

// ===== hw/rtl/crt_div.sv =====
// ----------------------------------------------------------------------------
// crt_div
// serial restoring divider, one quotient bit per cycle, floor quotient and
// non-negative remainder for a signed dividend and positive divisor
// ----------------------------------------------------------------------------
module crt_div #(
  parameter int EW = 32,
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [EW-1:0] dividend,
  input  logic        [DW-1:0] divisor,
  output logic                 done,
  output logic signed [EW-1:0] quo,
  output logic        [DW-1:0] rem
);

  localparam int CNW = $clog2(EW);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [EW-1:0]  mag;
  logic [DW-1:0]  part;
  logic [DW-1:0]  den;
  logic           neg;
  logic [DW:0]    trial;
  logic           fits;

  assign trial = {part, mag[EW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNW'(EW - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[EW-1];
      mag  <= dividend[EW-1] ? EW'(-dividend) : dividend;
      part <= '0;
      den  <= divisor;
    end else if (busy) begin
      if (fits) begin
        part <= DW'(trial - {1'b0, den});
      end else begin
        part <= trial[DW-1:0];
      end
      mag <= {mag[EW-2:0], fits};
    end
  end

  always_comb begin
    if (!neg) begin
      quo = mag;
      rem = part;
    end else if (part != '0) begin
      quo = -(mag + 1'b1);
      rem = den - part;
    end else begin
      quo = -mag;
      rem = '0;
    end
  end

endmodule

// ===== hw/rtl/crt_dp.sv =====
// ----------------------------------------------------------------------------
// crt_dp
// tessellator datapath: point history, step count search, coefficient and
// difference setup through the divider, exact forward-difference sampling
// ----------------------------------------------------------------------------
module crt_dp #(
  parameter int MAX_STEPS = crt_pkg::MAX_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  crt_pkg::crt_cmd_t         cmd,
  output crt_pkg::crt_stat_t        stat,
  input  logic [crt_pkg::SPW-1:0]   spacing,
  input  logic signed [crt_pkg::CW-1:0] in_x,
  input  logic signed [crt_pkg::CW-1:0] in_y,
  input  logic [crt_pkg::VW-1:0]    in_v,
  input  logic                      in_end,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [crt_pkg::CW-1:0] out_x,
  output logic signed [crt_pkg::CW-1:0] out_y,
  output logic [crt_pkg::VW-1:0]    out_v,
  output logic                      out_last
);

  import crt_pkg::*;

  localparam int NW   = $clog2(MAX_STEPS + 1);
  localparam int MSW  = SPW + NW;
  localparam int SQW  = 2 * MSW;
  localparam int CMPW = (SQW > 34) ? SQW : 34;
  localparam int EW   = 22 + 2 * NW;
  localparam int DW   = 3 * NW + 1;
  localparam logic [NW-1:0] MAXN = NW'(MAX_STEPS);

  function automatic logic signed [EW-1:0] sx(input logic signed [CW-1:0] p);
    return {{(EW-CW){p[CW-1]}}, p};
  endfunction

  function automatic logic [EW+DW-1:0] padd(
    input logic signed [EW-1:0] qa, input logic [DW-1:0] ra,
    input logic signed [EW-1:0] qb, input logic [DW-1:0] rb,
    input logic [DW-1:0] den);
    logic [DW:0]         s;
    logic signed [EW-1:0] q;
    logic [DW-1:0]       r;
    s = {1'b0, ra} + {1'b0, rb};
    if (s >= {1'b0, den}) begin
      r = DW'(s - {1'b0, den});
      q = qa + qb + 1'b1;
    end else begin
      r = s[DW-1:0];
      q = qa + qb;
    end
    return {q, r};
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] q);
    if (q > sx(16'sh7fff)) begin
      return 16'sh7fff;
    end else if (q < sx(16'sh8000)) begin
      return 16'sh8000;
    end else begin
      return q[CW-1:0];
    end
  endfunction

  // latched input word and history
  logic signed [CW-1:0] cx, cy;
  logic [VW-1:0]        cv;
  logic                 cend;
  logic signed [CW-1:0] hx [3];
  logic signed [CW-1:0] hy [3];
  logic [VW-1:0]        hv [3];
  logic [1:0]           points_seen;

  // control points of the current segment
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic signed [CW-1:0] sel_x [4];
  logic signed [CW-1:0] sel_y [4];
  logic [VW-1:0]        va, vb, sel_va, sel_vb;
  logic signed [CW:0]   dx, dy;

  // step count search
  logic [33:0]     dsum;
  logic [MSW-1:0]  ms;
  logic [NW-1:0]   m;
  logic [SQW-1:0]  sq;
  logic            step_go;
  logic [SPW-1:0]  s_eff;
  logic [NW-1:0]   n, n_new;
  logic [2*NW-1:0] n2;
  logic [3*NW-1:0] n3;
  logic [DW-1:0]   den_c, den_v;

  // setup
  logic signed [EW-1:0] a1x, a2x, a3x, a1y, a2y, a3y, dv;
  logic signed [EW-1:0] ca, cb, cc, nsx, t, e;
  logic                 div_done;
  logic signed [EW-1:0] dq;
  logic [DW-1:0]        dr;

  // accumulators
  logic signed [EW-1:0] qnx, q1x, q2x, q3x, qny, q1y, q2y, q3y, qv, qdv;
  logic [DW-1:0]        rnx, r1x, r2x, r3x, rny, r1y, r2y, r3y, rv, rdv;
  logic [NW-1:0]        k;

  logic signed [33:0] dxsq, dysq;

  assign dxsq = dx * dx;
  assign dysq = dy * dy;

  always_comb begin
    if (cmd.seg == SEG_MAIN) begin
      sel_x[0] = (points_seen == 2'd2) ? hx[1] : hx[0];
      sel_y[0] = (points_seen == 2'd2) ? hy[1] : hy[0];
      sel_x[1] = hx[1];
      sel_y[1] = hy[1];
      sel_x[2] = hx[2];
      sel_y[2] = hy[2];
      sel_x[3] = cx;
      sel_y[3] = cy;
      sel_va   = hv[1];
      sel_vb   = hv[2];
    end else begin
      sel_x[0] = (points_seen >= 2'd2) ? hx[1] : hx[2];
      sel_y[0] = (points_seen >= 2'd2) ? hy[1] : hy[2];
      sel_x[1] = hx[2];
      sel_y[1] = hy[2];
      sel_x[2] = cx;
      sel_y[2] = cy;
      sel_x[3] = cx;
      sel_y[3] = cy;
      sel_va   = hv[2];
      sel_vb   = cv;
    end
  end

  assign s_eff   = (spacing < MIN_SPACING) ? MIN_SPACING : spacing;
  assign sq      = ms * ms;
  assign step_go = (m != MAXN) && (CMPW'(sq) <= CMPW'(dsum));
  assign n_new   = (m == '0) ? NW'(1) : m;
  assign den_c   = {n3, 1'b0};
  assign den_v   = DW'({n, 1'b0});
  assign nsx     = {{(EW-NW){1'b0}}, n};

  assign a1x = sx(px[2]) - sx(px[0]);
  assign a2x = (sx(px[0]) <<< 1) - (sx(px[1]) <<< 2) - sx(px[1])
             + (sx(px[2]) <<< 2) - sx(px[3]);
  assign a3x = sx(px[1]) + (sx(px[1]) <<< 1) - sx(px[2]) - (sx(px[2]) <<< 1)
             + sx(px[3]) - sx(px[0]);
  assign a1y = sx(py[2]) - sx(py[0]);
  assign a2y = (sx(py[0]) <<< 1) - (sx(py[1]) <<< 2) - sx(py[1])
             + (sx(py[2]) <<< 2) - sx(py[3]);
  assign a3y = sx(py[1]) + (sx(py[1]) <<< 1) - sx(py[2]) - (sx(py[2]) <<< 1)
             + sx(py[3]) - sx(py[0]);
  assign dv  = ({{(EW-VW){1'b0}}, vb} - {{(EW-VW){1'b0}}, va}) <<< 1;

  always_comb begin
    ca = '0;
    cb = '0;
    cc = '0;
    unique case (cmd.job)
      JOB_X1: begin
        ca = a1x;
        cb = a2x;
        cc = a3x;
      end
      JOB_X2: begin
        cb = a2x <<< 1;
        cc = (a3x <<< 2) + (a3x <<< 1);
      end
      JOB_X3: cc = (a3x <<< 2) + (a3x <<< 1);
      JOB_Y1: begin
        ca = a1y;
        cb = a2y;
        cc = a3y;
      end
      JOB_Y2: begin
        cb = a2y <<< 1;
        cc = (a3y <<< 2) + (a3y <<< 1);
      end
      JOB_Y3: cc = (a3y <<< 2) + (a3y <<< 1);
      JOB_V:  cc = dv;
      default: cc = '0;
    endcase
  end

  crt_div #(
    .EW(EW),
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(e),
    .divisor ((cmd.job == JOB_V) ? den_v : den_c),
    .done    (div_done),
    .quo     (dq),
    .rem     (dr)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        hx[i] <= '0;
        hy[i] <= '0;
        hv[i] <= '0;
      end
    end else begin
      if (cmd.emit_sample || cmd.emit_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        if (cend) begin
          points_seen <= '0;
        end else begin
          hx[0] <= hx[1];
          hy[0] <= hy[1];
          hv[0] <= hv[1];
          hx[1] <= hx[2];
          hy[1] <= hy[2];
          hv[1] <= hv[2];
          hx[2] <= cx;
          hy[2] <= cy;
          hv[2] <= cv;
          if (points_seen != 2'd3) begin
            points_seen <= points_seen + 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cx   <= in_x;
      cy   <= in_y;
      cv   <= in_v;
      cend <= in_end;
    end
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        px[i] <= sel_x[i];
        py[i] <= sel_y[i];
      end
      va <= sel_va;
      vb <= sel_vb;
      dx <= {sel_x[2][CW-1], sel_x[2]} - {sel_x[1][CW-1], sel_x[1]};
      dy <= {sel_y[2][CW-1], sel_y[2]} - {sel_y[1][CW-1], sel_y[1]};
    end
    if (cmd.sq_dx) begin
      dsum <= dxsq[33:0];
    end
    if (cmd.sq_dy) begin
      dsum <= dsum + dysq[33:0];
      ms   <= MSW'(s_eff);
      m    <= '0;
    end
    if (cmd.step && step_go) begin
      m  <= m + 1'b1;
      ms <= ms + MSW'(s_eff);
    end
    if (cmd.n2) begin
      n  <= n_new;
      n2 <= n_new * n_new;
    end
    if (cmd.n3) begin
      n3 <= n2 * n;
    end
    if (cmd.prep1) begin
      t <= ca * nsx + cb;
    end
    if (cmd.prep2) begin
      e <= t * nsx + cc;
    end
    if (cmd.div_store) begin
      unique case (cmd.job)
        JOB_X1: begin q1x <= dq; r1x <= dr; end
        JOB_X2: begin q2x <= dq; r2x <= dr; end
        JOB_X3: begin q3x <= dq; r3x <= dr; end
        JOB_Y1: begin q1y <= dq; r1y <= dr; end
        JOB_Y2: begin q2y <= dq; r2y <= dr; end
        JOB_Y3: begin q3y <= dq; r3y <= dr; end
        JOB_V:  begin qdv <= dq; rdv <= dr; end
        default: begin qdv <= dq; rdv <= dr; end
      endcase
    end
    if (cmd.run_init) begin
      qnx <= sx(px[1]);
      rnx <= DW'(n3);
      qny <= sx(py[1]);
      rny <= DW'(n3);
      qv  <= {{(EW-VW){1'b0}}, va};
      rv  <= DW'(n);
      k   <= '0;
    end
    if (cmd.emit_sample) begin
      out_x    <= sat(qnx);
      out_y    <= sat(qny);
      out_v    <= qv[VW-1:0];
      out_last <= 1'b0;
      {qnx, rnx} <= padd(qnx, rnx, q1x, r1x, den_c);
      {q1x, r1x} <= padd(q1x, r1x, q2x, r2x, den_c);
      {q2x, r2x} <= padd(q2x, r2x, q3x, r3x, den_c);
      {qny, rny} <= padd(qny, rny, q1y, r1y, den_c);
      {q1y, r1y} <= padd(q1y, r1y, q2y, r2y, den_c);
      {q2y, r2y} <= padd(q2y, r2y, q3y, r3y, den_c);
      {qv, rv}   <= padd(qv, rv, qdv, rdv, den_v);
      k          <= k + 1'b1;
    end
    if (cmd.emit_last) begin
      out_x    <= cx;
      out_y    <= cy;
      out_v    <= cv;
      out_last <= 1'b1;
    end
  end

  assign stat.points_seen = points_seen;
  assign stat.series_end  = cend;
  assign stat.step_go     = step_go;
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.k_last      = (k == n - 1'b1);

endmodule

// ===== hw/rtl/crt_ctrl.sv =====
// ----------------------------------------------------------------------------
// crt_ctrl
// tessellator sequencer: per point it runs up to two segments (setup, step
// search, seven divisions, sampling) and the closing sample of a series
// ----------------------------------------------------------------------------
module crt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output crt_pkg::crt_cmd_t   cmd,
  input  crt_pkg::crt_stat_t  stat
);

  import crt_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_LOAD   = 4'd2;
  localparam logic [3:0] ST_DX     = 4'd3;
  localparam logic [3:0] ST_DY     = 4'd4;
  localparam logic [3:0] ST_STEP   = 4'd5;
  localparam logic [3:0] ST_N2     = 4'd6;
  localparam logic [3:0] ST_N3     = 4'd7;
  localparam logic [3:0] ST_PREP1  = 4'd8;
  localparam logic [3:0] ST_PREP2  = 4'd9;
  localparam logic [3:0] ST_DIVGO  = 4'd10;
  localparam logic [3:0] ST_DIVW   = 4'd11;
  localparam logic [3:0] ST_RUNI   = 4'd12;
  localparam logic [3:0] ST_RUN    = 4'd13;
  localparam logic [3:0] ST_LAST   = 4'd14;
  localparam logic [3:0] ST_FINISH = 4'd15;

  logic [3:0]    state, state_next;
  logic          seg, seg_next;
  logic [JW-1:0] job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seg   <= SEG_MAIN;
      job   <= JOB_X1;
    end else begin
      state <= state_next;
      seg   <= seg_next;
      job   <= job_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.seg    = seg;
    cmd.job    = job;
    in_ready   = 1'b0;
    state_next = state;
    seg_next   = seg;
    job_next   = job;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.points_seen >= 2'd2) begin
          seg_next   = SEG_MAIN;
          state_next = ST_LOAD;
        end else if (stat.series_end && stat.points_seen != 2'd0) begin
          seg_next   = SEG_TAIL;
          state_next = ST_LOAD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DX;
      end
      ST_DX: begin
        cmd.sq_dx  = 1'b1;
        state_next = ST_DY;
      end
      ST_DY: begin
        cmd.sq_dy  = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (!stat.step_go) begin
          state_next = ST_N2;
        end
      end
      ST_N2: begin
        cmd.n2     = 1'b1;
        job_next   = JOB_X1;
        state_next = ST_N3;
      end
      ST_N3: begin
        cmd.n3     = 1'b1;
        state_next = ST_PREP1;
      end
      ST_PREP1: begin
        cmd.prep1  = 1'b1;
        state_next = ST_PREP2;
      end
      ST_PREP2: begin
        cmd.prep2  = 1'b1;
        state_next = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVW;
      end
      ST_DIVW: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (job == JOB_V) begin
            state_next = ST_RUNI;
          end else begin
            job_next   = job + 1'b1;
            state_next = ST_PREP1;
          end
        end
      end
      ST_RUNI: begin
        cmd.run_init = 1'b1;
        state_next   = ST_RUN;
      end
      ST_RUN: begin
        if (stat.out_free) begin
          cmd.emit_sample = 1'b1;
          if (stat.k_last) begin
            if (seg == SEG_MAIN && stat.series_end) begin
              seg_next   = SEG_TAIL;
              state_next = ST_LOAD;
            end else if (seg == SEG_TAIL) begin
              state_next = ST_LAST;
            end else begin
              state_next = ST_FINISH;
            end
          end
        end
      end
      ST_LAST: begin
        if (stat.out_free) begin
          cmd.emit_last = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/catmull_rom_polyline_tessellator.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_polyline_tessellator
// turns a stream of screen points into uniform catmull-rom curve samples
// ----------------------------------------------------------------------------
// One point word is taken at a time; the block is busy until every sample it
// causes has been handed to the output register. Each segment first runs a
// setup: a step count search of up to MAX_STEPS steps, one squaring per
// cycle, and seven serial divisions at one quotient bit per cycle, which
// dominate the setup. Then the segment gives one sample per cycle while the
// output is taken. A point closes zero, one or two segments.
`include "catmull_rom_polyline_tessellator_defines.svh"

module catmull_rom_polyline_tessellator #(
  parameter int MAX_STEPS = crt_pkg::MAX_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // point_x [15:0], point_y [31:16], point_vis [40:32]
  input  logic [47:0]              s_axis_tdata,
  input  logic                     s_axis_tlast,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // sample_x [15:0], sample_y [31:16], sample_vis [40:32]
  output logic [47:0]              m_axis_tdata,
  output logic                     m_axis_tlast,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [crt_pkg::AW-1:0]   paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import crt_pkg::*;

  logic [SPW-1:0]       spacing;
  logic                 cfg_wr;
  crt_cmd_t             cmd;
  crt_stat_t            stat;
  logic signed [CW-1:0] sx_out, sy_out;
  logic [VW-1:0]        sv_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_SPACING);
  assign prdata = (paddr == ADDR_SPACING) ? {{(32-SPW){1'b0}}, spacing} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (cfg_wr) begin
      spacing <= pwdata[SPW-1:0];
    end
  end

  crt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

  crt_dp #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .spacing  (spacing),
    .in_x     (s_axis_tdata[15:0]),
    .in_y     (s_axis_tdata[31:16]),
    .in_v     (s_axis_tdata[40:32]),
    .in_end   (s_axis_tlast),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_x    (sx_out),
    .out_y    (sy_out),
    .out_v    (sv_out),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, sv_out, sy_out, sx_out};

  `CRT_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CRT_ASSERT_NXT(a_cfg_write, cfg_wr, spacing == $past(pwdata[SPW-1:0]))
  `CRT_ASSERT_IMP(a_idle_after_reset, $fell(rst), s_axis_tready && !m_axis_tvalid)

endmodule
